// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge, held off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lpce_pkg.sv =====
// ----------------------------------------------------------------------------
// lpce_pkg
// types, constants and the crc step for the link packet checksum engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpce_pkg;

   // field widths
   localparam int BYTE_WIDTH = 8;
   localparam int WORD_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   // payload length limit
   localparam logic [BYTE_WIDTH-1:0] MAX_PAYLOAD = 8'd255;

   // register reset values
   localparam logic [WORD_WIDTH-1:0] FRAME_CONSTANT_RESET = 16'h54FD;
   localparam logic [WORD_WIDTH-1:0] SOURCE_ADDRESS_RESET = 16'h6400;
   localparam logic [WORD_WIDTH-1:0] DESTINATION_ADDRESS_RESET = 16'h6401;

   // item kinds
   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   // register word indexes
   typedef enum logic [1:0] {
      CSR_FRAME_CONSTANT      = 2'd0,
      CSR_SOURCE_ADDRESS      = 2'd1,
      CSR_DESTINATION_ADDRESS = 2'd2
   } csr_index_type;

   // one payload byte folded into the crc register
   function automatic logic [WORD_WIDTH-1:0] crc_fold(
      input logic [WORD_WIDTH-1:0] c,
      input logic [BYTE_WIDTH-1:0] b
   );
      logic [WORD_WIDTH-1:0] t;
      logic [WORD_WIDTH-1:0] n;
      t = (c << 12) ^ (c << 8);
      n = {b, c[WORD_WIDTH-1:BYTE_WIDTH]};
      return n ^ t ^ (t >> 5) ^ (t >> 12);
   endfunction

   // both bytes of a word, modulo 256
   function automatic logic [BYTE_WIDTH-1:0] word_bytes(input logic [WORD_WIDTH-1:0] w);
      return w[BYTE_WIDTH-1:0] + w[WORD_WIDTH-1:BYTE_WIDTH];
   endfunction

endpackage

// ===== rtl/core/lpce_req_if.sv =====
// ----------------------------------------------------------------------------
// lpce_req_if
// request channel: payload bytes and end-of-packet header fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpce_req_if;
   import lpce_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [BYTE_WIDTH-1:0] data_byte;
   logic [WORD_WIDTH-1:0] src_service;
   logic [WORD_WIDTH-1:0] dst_service;
   logic [BYTE_WIDTH-1:0] ack_flag;
   logic [BYTE_WIDTH-1:0] sequence_number;

   modport source (
      output valid, kind, data_byte, src_service, dst_service, ack_flag, sequence_number,
      input  ready
   );

   modport sink (
      input  valid, kind, data_byte, src_service, dst_service, ack_flag, sequence_number,
      output ready
   );
endinterface

// ===== rtl/core/lpce_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lpce_rsp_if
// response channel: the check fields of one finished packet
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpce_rsp_if;
   import lpce_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] payload_crc;
   logic [BYTE_WIDTH-1:0] header_check;
   logic [BYTE_WIDTH-1:0] payload_len;
   logic                  overflow;

   modport source (
      output valid, payload_crc, header_check, payload_len, overflow,
      input  ready
   );

   modport sink (
      input  valid, payload_crc, header_check, payload_len, overflow,
      output ready
   );
endinterface

// ===== rtl/core/link_packet_checksum_engine.sv =====
// ----------------------------------------------------------------------------
// link_packet_checksum_engine
// crc and header checksum generator for outgoing link packets
// ----------------------------------------------------------------------------
// Usage:
//  req_ch takes one transfer per item: kind 0 carries a payload byte, kind 1
//  ends the packet and carries services, ack and sequence number. rsp_ch
//  gives one transfer per packet end with payload_crc, header_check,
//  payload_len and overflow. Payload bytes give no response.
//  An end item accepted on req_ch passes the input register, then the result
//  register, which drives its response on rsp_ch.
//  Throughput: one item per cycle but for end items in a receiver stall; the crc
//  xor network and fifteen-byte header sum fit between input and result register.
//  Bytes beyond 255 in a packet are dropped and flag overflow.
//  Receiver stall: the result register holds; payload bytes keep flowing,
//  and a second end item waits in the input register, with req_ch.ready
//  low, until the result register frees.
//  Reset (synchronous, high): channels empty, packet state cleared, header
//  registers back to 0x54FD, 0x6400, 0x6401. The csr_ port writes them
//  with an apb setup and access cycle at byte addresses 0, 4, 8.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module link_packet_checksum_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   lpce_req_if.sink                             req_ch,
   lpce_rsp_if.source                           rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lpce_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [lpce_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [lpce_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import lpce_pkg::*;

   // header registers
   logic [WORD_WIDTH-1:0] frame_constant_ff;
   logic [WORD_WIDTH-1:0] source_address_ff;
   logic [WORD_WIDTH-1:0] destination_address_ff;
   csr_index_type         csr_index;
   logic                  csr_write;

   // input register
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   kind_type              s1_kind_ff;
   logic [BYTE_WIDTH-1:0] s1_data_ff;
   logic [WORD_WIDTH-1:0] s1_src_ff;
   logic [WORD_WIDTH-1:0] s1_dst_ff;
   logic [BYTE_WIDTH-1:0] s1_ack_ff;
   logic [BYTE_WIDTH-1:0] s1_seq_ff;

   // packet state
   logic [WORD_WIDTH-1:0] crc_ff;
   logic [WORD_WIDTH-1:0] crc_in;
   logic [BYTE_WIDTH-1:0] count_ff;
   logic [BYTE_WIDTH-1:0] count_in;
   logic                  count_ovf_ff;
   logic                  count_ovf_in;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [WORD_WIDTH-1:0] rsp_check_ff;
   logic [BYTE_WIDTH-1:0] rsp_header_ff;
   logic [BYTE_WIDTH-1:0] rsp_size_ff;
   logic                  rsp_ovf_ff;

   // flow control
   logic                  out_free;
   logic                  s1_go;
   logic                  s1_end;
   logic                  req_take;
   logic [BYTE_WIDTH-1:0] header_sum;

   // apb access
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_constant_ff      <= FRAME_CONSTANT_RESET;
         source_address_ff      <= SOURCE_ADDRESS_RESET;
         destination_address_ff <= DESTINATION_ADDRESS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_CONSTANT:      frame_constant_ff      <= csr_pwdata[WORD_WIDTH-1:0];
            CSR_SOURCE_ADDRESS:      source_address_ff      <= csr_pwdata[WORD_WIDTH-1:0];
            CSR_DESTINATION_ADDRESS: destination_address_ff <= csr_pwdata[WORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         CSR_FRAME_CONSTANT:      csr_prdata[WORD_WIDTH-1:0] = frame_constant_ff;
         CSR_SOURCE_ADDRESS:      csr_prdata[WORD_WIDTH-1:0] = source_address_ff;
         CSR_DESTINATION_ADDRESS: csr_prdata[WORD_WIDTH-1:0] = destination_address_ff;
         default:                 csr_prdata = '0;
      endcase
   end

   // handshakes: payload bytes never wait on the result register
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_go        = s1_valid_ff && ((s1_kind_ff == KIND_DATA) || out_free);
   assign s1_end       = s1_go && (s1_kind_ff == KIND_END);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_go);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff <= kind_type'(req_ch.kind);
         s1_data_ff <= req_ch.data_byte;
         s1_src_ff  <= req_ch.src_service;
         s1_dst_ff  <= req_ch.dst_service;
         s1_ack_ff  <= req_ch.ack_flag;
         s1_seq_ff  <= req_ch.sequence_number;
      end
   end

   // fifteen header bytes, modulo 256
   assign header_sum = word_bytes(frame_constant_ff) + word_bytes(source_address_ff)
                     + word_bytes(s1_src_ff) + word_bytes(destination_address_ff)
                     + word_bytes(s1_dst_ff) + word_bytes(crc_ff)
                     + count_ff + s1_ack_ff + s1_seq_ff;

   // packet state update
   always_comb begin
      crc_in       = crc_ff;
      count_in     = count_ff;
      count_ovf_in = count_ovf_ff;
      if (s1_go) begin
         if (s1_kind_ff == KIND_END) begin
            crc_in       = '0;
            count_in     = '0;
            count_ovf_in = 1'b0;
         end else if (count_ff >= MAX_PAYLOAD) begin
            count_ovf_in = 1'b1;
         end else begin
            crc_in   = crc_fold(crc_ff, s1_data_ff);
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         count_ff     <= '0;
         count_ovf_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         count_ovf_ff <= count_ovf_in;
      end
   end

   // result register
   assign rsp_valid_in = s1_end || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_end) begin
         rsp_check_ff  <= crc_ff;
         rsp_header_ff <= header_sum;
         rsp_size_ff   <= count_ff;
         rsp_ovf_ff    <= count_ovf_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.payload_crc  = rsp_check_ff;
   assign rsp_ch.header_check = rsp_header_ff;
   assign rsp_ch.payload_len  = rsp_size_ff;
   assign rsp_ch.overflow     = rsp_ovf_ff;

   // checks
   `ASSERT_CLK(a_clear_after_end, clock, reset,
      s1_end |=> (crc_ff == '0) && (count_ff == '0) && !count_ovf_ff,
      "packet state not cleared after end item")
   `ASSERT_CLK(a_count_limit, clock, reset, count_ff <= MAX_PAYLOAD,
      "byte count above payload limit")
   `ASSERT_CLK(a_ovf_saturated, clock, reset, count_ovf_ff |-> (count_ff == MAX_PAYLOAD),
      "overflow set with unsaturated count")
   `ASSERT_CLK(a_end_waits, clock, reset,
      (s1_valid_ff && (s1_kind_ff == KIND_END) && !out_free) |=> s1_valid_ff && $stable(s1_kind_ff),
      "end item lost while result register busy")

endmodule
